>>> design/midpoint_circle_rasterizer_unit_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_MACROS_SVH

// same-cycle implication
`define MCR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcr same-cycle check failed");

// next-cycle implication
`define MCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcr next-cycle check failed");

`endif

>>> design/mcr_pkg.sv
`default_nettype none

package mcr_pkg;

  localparam int COORD_IN_W  = 14;
  localparam int COORD_OUT_W = 15;
  localparam int DIAM_W      = 12;
  localparam int LEN_W       = 12;
  localparam int LEN_MAX     = 4095;
  localparam int IDX_W       = 3;
  localparam int TDATA_IN_W  = 48;
  localparam int TDATA_OUT_W = 48;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t IDX_SINGLE   = 3'd0;
  localparam idx_t IDX_PAIR     = 3'd1;
  localparam idx_t IDX_QUAD     = 3'd3;
  localparam idx_t IDX_OCTANTS  = 3'd7;

  typedef enum logic [1:0] {
    GK_AXIS,
    GK_OCT,
    GK_SPAN
  } grp_kind_e;

  typedef struct packed {
    logic      valid;
    grp_kind_e kind;
    idx_t      last_idx;
    logic      done;
  } grp_ctrl_t;

endpackage

`default_nettype wire

>>> design/mcr_core.sv
`default_nettype none

module mcr_core #(
  parameter int RADIUS_BITS = 11
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  input  wire logic                                   take_i,
  input  wire logic                                   cmd_i,
  input  wire logic signed [mcr_pkg::COORD_IN_W-1:0]  cx_i,
  input  wire logic signed [mcr_pkg::COORD_IN_W-1:0]  cy_i,
  input  wire logic        [mcr_pkg::DIAM_W-1:0]      diam_i,
  input  wire logic                                   fill_i,
  output mcr_pkg::grp_ctrl_t                          grp_o,
  output logic signed      [mcr_pkg::COORD_IN_W-1:0]  cx_o,
  output logic signed      [mcr_pkg::COORD_IN_W-1:0]  cy_o,
  output logic             [RADIUS_BITS-1:0]          mj_o,
  output logic             [RADIUS_BITS-1:0]          mn_o
);
  import mcr_pkg::*;

  localparam int DW = RADIUS_BITS + 3;
  localparam int WR = (RADIUS_BITS > DIAM_W - 1) ? RADIUS_BITS : DIAM_W - 1;
  localparam logic signed [DW-1:0] ONE = DW'(1);

  logic signed [COORD_IN_W-1:0] center_col_q, center_col_d;
  logic signed [COORD_IN_W-1:0] center_row_q, center_row_d;
  logic [RADIUS_BITS-1:0]       major_q, major_d;
  logic [RADIUS_BITS-1:0]       minor_q, minor_d;
  logic signed [DW-1:0]         dec_q, dec_d;
  logic                         fill_q, fill_d;
  logic                         active_q, active_d;

  logic [WR-1:0]                r_ext;
  logic [WR-1:0]                rmax_ext;
  logic [RADIUS_BITS-1:0]       radius;
  logic signed [DW-1:0]         dec_start;
  logic [RADIUS_BITS-1:0]       mn_step, mj_step;
  logic signed [DW-1:0]         mn_s, mj_s, dec_step;
  logic                         cur_emits, done;

  // look-ahead: does one more iteration still emit
  function automatic logic emits(input logic [RADIUS_BITS-1:0] mj,
                                 input logic [RADIUS_BITS-1:0] mn,
                                 input logic signed [DW-1:0]   d);
    logic [RADIUS_BITS:0] mj1;
    logic [RADIUS_BITS:0] mn1;
    begin
      mn1 = {1'b0, mn} + 1'b1;
      mj1 = (d > 0) ? ({1'b0, mj} - 1'b1) : {1'b0, mj};
      return (mj > mn) && (mj1 >= mn1);
    end
  endfunction

  assign r_ext     = WR'(diam_i[DIAM_W-1:1]);
  assign rmax_ext  = WR'({RADIUS_BITS{1'b1}});
  assign radius    = (r_ext > rmax_ext) ? RADIUS_BITS'(rmax_ext) : RADIUS_BITS'(r_ext);
  assign dec_start = ONE - $signed(DW'(radius));

  assign cur_emits = emits(major_q, minor_q, dec_q);
  assign mn_step   = minor_q + 1'b1;
  assign mj_step   = (dec_q > 0) ? (major_q - 1'b1) : major_q;
  assign mn_s      = $signed(DW'(mn_step));
  assign mj_s      = $signed(DW'(mj_step));
  assign dec_step  = (dec_q > 0) ? (dec_q + ((mn_s - mj_s) <<< 1) + ONE)
                                 : (dec_q + (mn_s <<< 1) + ONE);

  always_comb begin
    center_col_d = center_col_q;
    center_row_d = center_row_q;
    major_d      = major_q;
    minor_d      = minor_q;
    dec_d        = dec_q;
    fill_d       = fill_q;
    active_d     = active_q;
    done         = 1'b0;
    grp_o        = '{valid: 1'b0, kind: GK_AXIS, last_idx: IDX_SINGLE, done: 1'b0};
    if (cmd_i == CMD_START) begin
      center_col_d = cx_i;
      center_row_d = cy_i;
      fill_d       = fill_i;
      major_d      = radius;
      minor_d      = '0;
      dec_d        = dec_start;
      done         = (radius == '0) || !emits(radius, '0, dec_start);
      active_d     = !done;
      grp_o.valid  = in_valid_i;
      grp_o.done   = done;
      if (radius == '0) begin
        grp_o.kind     = GK_AXIS;
        grp_o.last_idx = IDX_SINGLE;
      end else if (fill_i) begin
        grp_o.kind     = GK_SPAN;
        grp_o.last_idx = IDX_SINGLE;
      end else begin
        grp_o.kind     = GK_AXIS;
        grp_o.last_idx = IDX_QUAD;
      end
    end else if (active_q) begin
      if (cur_emits) begin
        major_d     = mj_step;
        minor_d     = mn_step;
        dec_d       = dec_step;
        done        = !emits(mj_step, mn_step, dec_step);
        active_d    = !done;
        grp_o.valid = in_valid_i;
        grp_o.done  = done;
        if (fill_q) begin
          grp_o.kind     = GK_SPAN;
          grp_o.last_idx = (mj_step != mn_step) ? IDX_QUAD : IDX_PAIR;
        end else begin
          grp_o.kind     = GK_OCT;
          grp_o.last_idx = (mj_step != mn_step) ? IDX_OCTANTS : IDX_QUAD;
        end
      end else begin
        active_d = 1'b0;
      end
    end
  end

  assign cx_o = center_col_d;
  assign cy_o = center_row_d;
  assign mj_o = major_d;
  assign mn_o = minor_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q <= '0;
      center_row_q <= '0;
      major_q      <= '0;
      minor_q      <= '0;
      dec_q        <= '0;
      fill_q       <= 1'b0;
      active_q     <= 1'b0;
    end else if (take_i) begin
      center_col_q <= center_col_d;
      center_row_q <= center_row_d;
      major_q      <= major_d;
      minor_q      <= minor_d;
      dec_q        <= dec_d;
      fill_q       <= fill_d;
      active_q     <= active_d;
    end
  end

endmodule

`default_nettype wire

>>> design/mcr_emit.sv
`default_nettype none

module mcr_emit #(
  parameter int RADIUS_BITS = 11
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire mcr_pkg::grp_ctrl_t                     grp_i,
  input  wire logic signed [mcr_pkg::COORD_IN_W-1:0]  cx_i,
  input  wire logic signed [mcr_pkg::COORD_IN_W-1:0]  cy_i,
  input  wire logic        [RADIUS_BITS-1:0]          mj_i,
  input  wire logic        [RADIUS_BITS-1:0]          mn_i,
  output logic                                        grp_ready_o,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed      [mcr_pkg::COORD_OUT_W-1:0] out_x_o,
  output logic signed      [mcr_pkg::COORD_OUT_W-1:0] out_y_o,
  output logic             [mcr_pkg::LEN_W-1:0]       span_length_o,
  output logic                                        last_of_group_o,
  output logic                                        circle_done_o
);
  import mcr_pkg::*;

  localparam int LW = (RADIUS_BITS + 1 > LEN_W) ? RADIUS_BITS + 1 : LEN_W;

  logic                         grp_valid_q, grp_valid_d;
  grp_kind_e                    kind_q;
  idx_t                         last_q;
  logic                         done_q;
  logic signed [COORD_IN_W-1:0] cx_q, cy_q;
  logic [RADIUS_BITS-1:0]       mj_q, mn_q;
  idx_t                         k_q, k_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_OUT_W-1:0] out_x_q, out_y_q;
  logic [LEN_W-1:0]             out_len_q;
  logic                         out_last_q, out_done_q;

  logic                         emit_fire, is_last;
  logic                         swap, x_neg, y_neg, use_x, use_y, is_span;
  logic [RADIUS_BITS-1:0]       p, q, x_mag, y_mag;
  logic [COORD_OUT_W-1:0]       xm15, ym15, x_off, y_off;
  logic [COORD_OUT_W-1:0]       x_res, y_res;
  logic [LW-1:0]                len_full;
  logic [LEN_W-1:0]             len_res;

  assign emit_fire   = grp_valid_q && (!out_valid_q || out_ready_i);
  assign is_last     = (k_q == last_q);
  assign grp_ready_o = !grp_valid_q || (emit_fire && is_last);

  always_comb begin
    swap    = 1'b0;
    x_neg   = 1'b0;
    y_neg   = 1'b0;
    use_x   = 1'b1;
    use_y   = 1'b1;
    is_span = 1'b0;
    case (kind_q)
      GK_AXIS: begin
        use_x = (k_q[1:0] == 2'd0) || (k_q[1:0] == 2'd3);
        use_y = !use_x;
        x_neg = k_q[0];
        y_neg = !k_q[1];
      end
      GK_OCT: begin
        swap  = k_q[2];
        x_neg = k_q[0];
        y_neg = k_q[1];
      end
      GK_SPAN: begin
        swap    = k_q[1];
        x_neg   = 1'b1;
        y_neg   = !k_q[0];
        is_span = 1'b1;
      end
      default: begin
        use_x = 1'b0;
        use_y = 1'b0;
      end
    endcase
  end

  // axis points carry the radius on one side only
  assign p     = swap ? mn_q : mj_q;
  assign q     = (kind_q == GK_AXIS) ? mj_q : (swap ? mj_q : mn_q);
  assign x_mag = use_x ? p : '0;
  assign y_mag = use_y ? q : '0;

  assign xm15  = COORD_OUT_W'(x_mag);
  assign ym15  = COORD_OUT_W'(y_mag);
  assign x_off = x_neg ? (~xm15 + 1'b1) : xm15;
  assign y_off = y_neg ? (~ym15 + 1'b1) : ym15;
  assign x_res = {cx_q[COORD_IN_W-1], cx_q} + x_off;
  assign y_res = {cy_q[COORD_IN_W-1], cy_q} + y_off;

  assign len_full = LW'({p, 1'b1});
  assign len_res  = !is_span ? LEN_W'(1)
                  : (len_full > LW'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(len_full);

  always_comb begin
    grp_valid_d = grp_valid_q;
    k_d         = k_q;
    if (grp_ready_o) begin
      grp_valid_d = grp_i.valid;
      k_d         = '0;
    end else if (emit_fire) begin
      k_d = k_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      grp_valid_q <= grp_valid_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_ready_o && grp_i.valid) begin
      kind_q <= grp_i.kind;
      last_q <= grp_i.last_idx;
      done_q <= grp_i.done;
      cx_q   <= cx_i;
      cy_q   <= cy_i;
      mj_q   <= mj_i;
      mn_q   <= mn_i;
    end
    if (emit_fire) begin
      out_x_q    <= $signed(x_res);
      out_y_q    <= $signed(y_res);
      out_len_q  <= len_res;
      out_last_q <= is_last;
      out_done_q <= is_last && done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign span_length_o   = out_len_q;
  assign last_of_group_o = out_last_q;
  assign circle_done_o   = out_done_q;

endmodule

`default_nettype wire

>>> design/midpoint_circle_rasterizer_unit.sv
// Midpoint circle rasterizer.
// Throughput: one result per cycle unless m_axis_tready stalls the output;
// a request holds the result emitter until it has emitted the last of its
// 1 to 8 results, and a request with no result does not enter the emitter.
// Reset: asynchronous, active low; clears the circle state (no circle active).
`default_nettype none
`include "midpoint_circle_rasterizer_unit_macros.svh"

module midpoint_circle_rasterizer_unit #(
  parameter int RADIUS_BITS = 11
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // center_x[13:0], center_y[27:14], diameter[39:28], fill[40], zero pad
  input  wire logic [mcr_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // command
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // out_x[14:0], out_y[29:15], span_length[41:30], zero pad
  output logic [mcr_pkg::TDATA_OUT_W-1:0]         m_axis_tdata,
  // last_of_group
  output logic                                    m_axis_tlast,
  // circle_done
  output logic                                    m_axis_tuser
);
  import mcr_pkg::*;

  logic                         in_valid_q;
  logic                         cmd_q, fill_q;
  logic signed [COORD_IN_W-1:0] cx_q, cy_q;
  logic [DIAM_W-1:0]            diam_q;
  logic                         grp_ready, consume, s_fire;

  grp_ctrl_t                    grp;
  logic signed [COORD_IN_W-1:0] grp_cx, grp_cy;
  logic [RADIUS_BITS-1:0]       grp_mj, grp_mn;

  logic signed [COORD_OUT_W-1:0] out_x, out_y;
  logic [LEN_W-1:0]             out_len;

  assign consume       = in_valid_q && grp_ready;
  assign s_axis_tready = !in_valid_q || grp_ready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q  <= s_axis_tuser;
      cx_q   <= $signed(s_axis_tdata[13:0]);
      cy_q   <= $signed(s_axis_tdata[27:14]);
      diam_q <= s_axis_tdata[39:28];
      fill_q <= s_axis_tdata[40];
    end
  end

  mcr_core #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_q),
    .take_i    (consume),
    .cmd_i     (cmd_q),
    .cx_i      (cx_q),
    .cy_i      (cy_q),
    .diam_i    (diam_q),
    .fill_i    (fill_q),
    .grp_o     (grp),
    .cx_o      (grp_cx),
    .cy_o      (grp_cy),
    .mj_o      (grp_mj),
    .mn_o      (grp_mn)
  );

  mcr_emit #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grp_i          (grp),
    .cx_i           (grp_cx),
    .cy_i           (grp_cy),
    .mj_i           (grp_mj),
    .mn_i           (grp_mn),
    .grp_ready_o    (grp_ready),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .span_length_o  (out_len),
    .last_of_group_o(m_axis_tlast),
    .circle_done_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {{(TDATA_OUT_W - 2 * COORD_OUT_W - LEN_W){1'b0}},
                         out_len, out_y, out_x};

  `MCR_ASSERT_SAME(a_done_on_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  `MCR_ASSERT_SAME(a_len_nonzero, m_axis_tvalid, out_len != '0)
  `MCR_ASSERT_NEXT(a_group_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                   m_axis_tvalid)

endmodule

`default_nettype wire

>>> tb/sv/tb_midpoint_circle_rasterizer_unit.sv
module tb_midpoint_circle_rasterizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mcr_pkg::*;

  localparam int RADIUS_MAX   = (1 << 11) - 1;
  localparam int TOTAL_ITEMS  = 350;
  localparam int PHASE_ITEMS  = TOTAL_ITEMS / 3;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [14:0] x;
    logic [14:0] y;
    logic [11:0] len;
    logic        last;
    logic        done;
  } pixel_t;

  typedef enum {
    ROW_PREDICT,
    ROW_NO_RESULT,
    ROW_SINGLE_POINT
  } row_check_e;

  typedef struct {
    logic        cmd;
    logic [13:0] cx;
    logic [13:0] cy;
    logic [11:0] diam;
    logic        fl;
    row_check_e  chk;
    logic [14:0] ex;
    logic [14:0] ey;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // center_x, center_y, diameter, fill, zero pad
  logic        s_axis_tuser = CMD_START;  // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;  // out_x, out_y, span_length, zero pad
  logic        m_axis_tlast;  // last_of_group
  logic        m_axis_tuser;  // circle_done

  // circle state of the predictor
  int          rc_col;
  int          rc_row;
  int          rc_major;
  int          rc_minor;
  int          rc_decision;
  bit          rc_fill;
  bit          rc_active;

  pixel_t      group_buf[$];
  pixel_t      expected_pixels[$];
  pixel_t      want_px;
  row_t        directed_rows[$];
  int          mismatch_count = 0;
  int          emitting_requests = 0;
  int          src_idle_pct = 30;
  int          sink_stall_pct = 86;

  midpoint_circle_rasterizer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit iteration_emits();
    int mj;
    int mn;
    mj = rc_major;
    mn = rc_minor;
    if (mj <= mn) return 1'b0;
    mn++;
    if (rc_decision > 0) mj--;
    return mj >= mn;
  endfunction

  function automatic void add_pixel(int x, int y, int len);
    pixel_t p;
    p.x    = x[14:0];
    p.y    = y[14:0];
    p.len  = 12'((len > LEN_MAX) ? LEN_MAX : len);
    p.last = 1'b0;
    p.done = 1'b0;
    group_buf.push_back(p);
  endfunction

  // results of one request land in group_buf
  function automatic void rasterize_request(logic cmd, logic [13:0] cx, logic [13:0] cy,
                                            logic [11:0] diam, logic fl);
    int r;
    int mj;
    int mn;
    bit done;
    group_buf.delete();
    if (cmd == CMD_START) begin
      r = int'(diam >> 1);
      if (r > RADIUS_MAX) r = RADIUS_MAX;
      rc_col      = int'($signed(cx));
      rc_row      = int'($signed(cy));
      rc_fill     = fl;
      rc_major    = r;
      rc_minor    = 0;
      rc_decision = 1 - r;
      if (r == 0) begin
        rc_active = 1'b0;
        add_pixel(rc_col, rc_row, 1);
        done = 1'b1;
      end else if (rc_fill) begin
        add_pixel(rc_col - r, rc_row, 2 * r + 1);
        rc_active = 1'b1;
        done = !iteration_emits();
      end else begin
        add_pixel(rc_col + r, rc_row, 1);
        add_pixel(rc_col, rc_row - r, 1);
        add_pixel(rc_col, rc_row + r, 1);
        add_pixel(rc_col - r, rc_row, 1);
        rc_active = 1'b1;
        done = !iteration_emits();
      end
    end else begin
      if (!rc_active) return;
      if (!iteration_emits()) begin
        rc_active = 1'b0;
        return;
      end
      rc_minor++;
      if (rc_decision <= 0) begin
        rc_decision += 2 * rc_minor + 1;
      end else begin
        rc_major--;
        rc_decision += 2 * (rc_minor - rc_major) + 1;
      end
      mj = rc_major;
      mn = rc_minor;
      if (rc_fill) begin
        add_pixel(rc_col - mj, rc_row - mn, 2 * mj + 1);
        add_pixel(rc_col - mj, rc_row + mn, 2 * mj + 1);
        if (mj != mn) begin
          add_pixel(rc_col - mn, rc_row - mj, 2 * mn + 1);
          add_pixel(rc_col - mn, rc_row + mj, 2 * mn + 1);
        end
      end else begin
        add_pixel(rc_col + mj, rc_row + mn, 1);
        add_pixel(rc_col - mj, rc_row + mn, 1);
        add_pixel(rc_col + mj, rc_row - mn, 1);
        add_pixel(rc_col - mj, rc_row - mn, 1);
        if (mj != mn) begin
          add_pixel(rc_col + mn, rc_row + mj, 1);
          add_pixel(rc_col - mn, rc_row + mj, 1);
          add_pixel(rc_col + mn, rc_row - mj, 1);
          add_pixel(rc_col - mn, rc_row - mj, 1);
        end
      end
      done = !iteration_emits();
    end
    if (done) rc_active = 1'b0;
    group_buf[group_buf.size() - 1].last = 1'b1;
    group_buf[group_buf.size() - 1].done = done;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, got x=%0d y=%0d len=%0d", $time,
                 $signed(m_axis_tdata[14:0]), $signed(m_axis_tdata[29:15]),
                 m_axis_tdata[41:30]);
      end else begin
        want_px = expected_pixels.pop_front();
        check_field("out_x", int'($signed(want_px.x)), int'($signed(m_axis_tdata[14:0])));
        check_field("out_y", int'($signed(want_px.y)), int'($signed(m_axis_tdata[29:15])));
        check_field("span_length", int'(want_px.len), int'(m_axis_tdata[41:30]));
        check_field("last_of_group", int'(want_px.last), int'(m_axis_tlast));
        check_field("circle_done", int'(want_px.done), int'(m_axis_tuser));
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_request(input logic cmd, input logic [13:0] cx, input logic [13:0] cy,
                              input logic [11:0] diam, input logic fl,
                              input row_check_e chk, input logic [14:0] ex,
                              input logic [14:0] ey);
    pixel_t px;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {7'd0, fl, diam, cy, cx};
    do @(posedge clk_i); while (!s_axis_tready);
    rasterize_request(cmd, cx, cy, diam, fl);
    if (group_buf.size() != 0) emitting_requests++;
    case (chk)
      ROW_PREDICT: begin
        foreach (group_buf[i]) expected_pixels.push_back(group_buf[i]);
      end
      ROW_SINGLE_POINT: begin
        px = '{ex, ey, 12'd1, 1'b1, 1'b1};
        expected_pixels.push_back(px);
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_step();
    send_request(CMD_STEP, 14'($urandom), 14'($urandom), 12'($urandom), 1'($urandom),
                 ROW_PREDICT, '0, '0);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int phase;
    int sel;
    int nsteps;
    int steps_done;
    int extra;
    logic [11:0] diam;

    directed_rows = '{
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_NO_RESULT,    15'h0000, 15'h0000},
      '{CMD_START, 14'h0000, 14'h0000, 12'h000, 1'b0, ROW_SINGLE_POINT, 15'h0000, 15'h0000},
      '{CMD_START, 14'h1FFF, 14'h2000, 12'h001, 1'b1, ROW_SINGLE_POINT, 15'h1FFF, 15'h6000},
      '{CMD_STEP,  14'h3FFF, 14'h3FFF, 12'hFFF, 1'b1, ROW_NO_RESULT,    15'h0000, 15'h0000},
      '{CMD_START, 14'h2000, 14'h1FFF, 12'hFFF, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_START, 14'h1FFF, 14'h1FFF, 12'hFFF, 1'b1, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_START, 14'h0005, 14'h3FFD, 12'h002, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_NO_RESULT,    15'h0000, 15'h0000},
      '{CMD_START, 14'h0010, 14'h3FF0, 12'h005, 1'b1, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_START, 14'h0100, 14'h0200, 12'h006, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h0000, 14'h0000, 12'h000, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_START, 14'h2AAA, 14'h1555, 12'hAAA, 1'b0, ROW_PREDICT,      15'h0000, 15'h0000},
      '{CMD_STEP,  14'h1555, 14'h2AAA, 12'h555, 1'b1, ROW_PREDICT,      15'h0000, 15'h0000}
    };

    rc_col      = 0;
    rc_row      = 0;
    rc_major    = 0;
    rc_minor    = 0;
    rc_decision = 0;
    rc_fill     = 1'b0;
    rc_active   = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].cmd, directed_rows[i].cx, directed_rows[i].cy,
                   directed_rows[i].diam, directed_rows[i].fl, directed_rows[i].chk,
                   directed_rows[i].ex, directed_rows[i].ey);
    end

    phase = 0;
    while (emitting_requests < TOTAL_ITEMS) begin
      if (phase == 0 && emitting_requests >= PHASE_ITEMS) begin
        drain_results();
        src_idle_pct   = 86;
        sink_stall_pct = 30;
        phase = 1;
      end else if (phase == 1 && emitting_requests >= 2 * PHASE_ITEMS) begin
        drain_results();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        phase = 2;
      end

      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // stray advance: idle, or pushing an abandoned circle along
        send_step();
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 75) diam = 12'($urandom_range(0, 40));
        else if (sel < 93) diam = 12'($urandom_range(41, 300));
        else diam = 12'($urandom);
        send_request(CMD_START, 14'($urandom), 14'($urandom), diam, 1'($urandom),
                     ROW_PREDICT, '0, '0);
        if ($urandom_range(0, 4) == 0) nsteps = $urandom_range(0, 6);
        else nsteps = 100000;
        if (diam > 300 && nsteps > 12) nsteps = 12;
        else if (diam > 80 && nsteps > 30) nsteps = 30;
        steps_done = 0;
        while (rc_active && steps_done < nsteps) begin
          send_step();
          steps_done++;
        end
        if (!rc_active) begin
          extra = $urandom_range(0, 1);
          repeat (extra) send_step();
        end
      end
    end

    s_axis_tvalid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
